>>> sv/rpk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// R-peak detector package
// Shared widths, register map, reset values, types and the zone compare.
// ----------------------------------------------------------------------------
package rpk_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 16;
	localparam int RATE_W   = 16;
	localparam int REFR_W   = 8;

	// Register map: index i sits at byte address 4*i.
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_R_THRESHOLD  = 3'd0,
		REG_REFRACTORY   = 3'd1,
		REG_NUMERATOR    = 3'd2,
		REG_LOW_LIMIT    = 3'd3,
		REG_HIGH_LIMIT   = 3'd4
	} reg_idx_t;

	localparam logic signed [SAMPLE_W-1:0] R_THRESHOLD_RST = 16'sd400;
	localparam logic [REFR_W-1:0]          REFRACTORY_RST  = 8'd25;
	localparam logic [RATE_W-1:0]          NUMERATOR_RST   = 16'd6000;
	localparam logic [RATE_W-1:0]          LOW_LIMIT_RST   = 16'd60;
	localparam logic [RATE_W-1:0]          HIGH_LIMIT_RST  = 16'd80;

	// Depth of the command queue between the classifier and the divider.
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [1:0] {
		ZONE_LOW  = 2'd0,
		ZONE_MID  = 2'd1,
		ZONE_HIGH = 2'd2,
		ZONE_EDGE = 2'd3
	} zone_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] r_threshold;
		logic [REFR_W-1:0]          refractory_samples;
		logic [RATE_W-1:0]          rate_numerator;
		logic [RATE_W-1:0]          low_rate_limit;
		logic [RATE_W-1:0]          high_rate_limit;
	} cfg_t;

	// One classified sample on its way to the back end.
	typedef struct packed {
		logic               beat;
		logic [COUNT_W-1:0] count;
	} cmd_t;

	// The tests run in a fixed order, which also settles crossed limits.
	function automatic zone_t zone_of(input logic [RATE_W-1:0] rate,
			input logic [RATE_W-1:0] low, input logic [RATE_W-1:0] high);
		zone_t z;
		if (rate < low) begin
			z = ZONE_LOW;
		end else if (rate > low && rate < high) begin
			z = ZONE_MID;
		end else if (rate > high) begin
			z = ZONE_HIGH;
		end else begin
			z = ZONE_EDGE;
		end
		return z;
	endfunction

endpackage

>>> sv/rpk_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// R-peak detector front end
// Accepts samples, keeps the interbeat count and classifies beat or no beat.
// ----------------------------------------------------------------------------
module rpk_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic signed [rpk_pkg::SAMPLE_W-1:0] sample,
	input  rpk_pkg::cfg_t                   cfg,
	input  logic                            q_full,
	output logic                            q_push,
	output rpk_pkg::cmd_t                   q_cmd
);

	logic [rpk_pkg::COUNT_W-1:0] count_q;
	logic [rpk_pkg::COUNT_W-1:0] count_inc;
	logic                        is_beat;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// The count saturates at all ones rather than wrapping.
	assign count_inc = (&count_q) ? count_q : count_q + 1'b1;
	assign is_beat   = (sample > cfg.r_threshold) &&
		(count_inc > {{(rpk_pkg::COUNT_W-rpk_pkg::REFR_W){1'b0}}, cfg.refractory_samples});

	assign q_cmd.beat  = is_beat;
	assign q_cmd.count = count_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (q_push) begin
			count_q <= is_beat ? '0 : count_inc;
		end
	end

endmodule

>>> sv/rpk_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// R-peak detector command queue
// Small first-in first-out buffer that decouples the front and back ends.
// ----------------------------------------------------------------------------
module rpk_queue #(
	parameter int DEPTH = rpk_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rpk_pkg::cmd_t wr_cmd,
	input  logic          pop,
	output rpk_pkg::cmd_t rd_cmd,
	output logic          full,
	output logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	rpk_pkg::cmd_t    mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full   = (fill_q == FULL_CNT);
	assign empty  = (fill_q == '0);
	assign rd_cmd = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/rpk_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// R-peak detector back end
// Runs the rate divide for beats, keeps the rate and drives the result beat.
// ----------------------------------------------------------------------------
module rpk_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rpk_pkg::cfg_t                cfg,
	input  logic                         q_empty,
	input  rpk_pkg::cmd_t                q_cmd,
	output logic                         q_pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic                         beat_detected,
	output logic [rpk_pkg::RATE_W-1:0]   heart_rate,
	output logic [1:0]                   rate_zone
);

	localparam int STEP_W = $clog2(rpk_pkg::RATE_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(rpk_pkg::RATE_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t                      state_q;
	logic [rpk_pkg::RATE_W-1:0]  rate_q;
	logic [rpk_pkg::RATE_W-1:0]  quo_q;
	logic [rpk_pkg::RATE_W-1:0]  rem_q;
	logic [rpk_pkg::COUNT_W-1:0] div_q;
	logic [STEP_W-1:0]           step_q;
	logic                        out_valid_q;
	logic                        out_beat_q;
	logic [rpk_pkg::RATE_W-1:0]  out_rate_q;
	rpk_pkg::zone_t              out_zone_q;

	logic [rpk_pkg::RATE_W:0]    trial;
	logic [rpk_pkg::RATE_W:0]    diff;
	logic                        ge;
	logic [rpk_pkg::RATE_W-1:0]  quo_next;

	// One restoring step: bring in the next numerator bit, subtract if it fits.
	assign trial    = {rem_q, quo_q[rpk_pkg::RATE_W-1]};
	assign ge       = (trial >= {1'b0, div_q});
	assign diff     = trial - {1'b0, div_q};
	assign quo_next = {quo_q[rpk_pkg::RATE_W-2:0], ge};

	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	assign m_tvalid      = out_valid_q;
	assign beat_detected = out_beat_q;
	assign heart_rate    = out_rate_q;
	assign rate_zone     = out_zone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rate_q      <= '0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (q_cmd.beat) begin
							step_q  <= '0;
							state_q <= ST_DIV;
						end else begin
							out_valid_q <= 1'b1;
							state_q     <= ST_OUT;
						end
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						rate_q      <= quo_next;
						out_valid_q <= 1'b1;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				quo_q      <= cfg.rate_numerator;
				rem_q      <= '0;
				div_q      <= q_cmd.count;
				out_beat_q <= 1'b0;
				out_rate_q <= rate_q;
				out_zone_q <= rpk_pkg::zone_of(rate_q, cfg.low_rate_limit,
					cfg.high_rate_limit);
			end
			ST_DIV: begin
				quo_q      <= quo_next;
				rem_q      <= ge ? diff[rpk_pkg::RATE_W-1:0] : trial[rpk_pkg::RATE_W-1:0];
				out_beat_q <= 1'b1;
				out_rate_q <= quo_next;
				out_zone_q <= rpk_pkg::zone_of(quo_next, cfg.low_rate_limit,
					cfg.high_rate_limit);
			end
			default: begin
			end
		endcase
	end

	// A result is only shown while the back end is waiting for it to leave.
	a_valid_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == ST_OUT))
		else $error("result valid outside the output state");

	// The stored rate only changes when a divide finishes.
	a_rate_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DIV) |=> $stable(rate_q))
		else $error("rate changed without a divide");

	// The divide always takes the full number of steps and then presents a beat.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == LAST_STEP) |=> (out_valid_q && out_beat_q))
		else $error("divide did not end in a beat result");

	// A beat command never starts a divide by zero.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_cmd.beat) |-> (q_cmd.count != '0))
		else $error("beat command with zero interbeat count");

endmodule

>>> sv/r_peak_heart_rate_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// R-peak heart rate detector
// Threshold R-peak detector with refractory period and heart rate zoning.
// ----------------------------------------------------------------------------
// Each input beat carries one band-pass filtered ECG sample and yields exactly
// one result beat holding the beat flag, the latest heart rate and its zone.
// The front end takes a sample, updates the saturating interbeat count at once
// and queues a command, so it keeps accepting samples while the back end is
// busy, up to QUEUE_DEPTH samples ahead. For a sample that is not a beat the
// back end reads the queue with the result load, then waits for the handshake;
// for a beat it first divides the rate numerator by the interbeat count in a
// restoring divider that retires one quotient bit per cycle. Settings are
// written through the APB port at byte address 4*i (threshold, refractory
// length, numerator, low limit, high limit) and must only change while no
// sample is in flight; reads return the stored value.
// ----------------------------------------------------------------------------
module r_peak_heart_rate_detector #(
	parameter int QUEUE_DEPTH = rpk_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB configuration port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rpk_pkg::PADDR_W-1:0] paddr,
	input  logic [rpk_pkg::PDATA_W-1:0] pwdata,
	output logic [rpk_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	// Sample stream in.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,   // [15:0] sample
	// Result stream out.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata    // [0] beat_detected,
	                                               // [16:1] heart_rate,
	                                               // [18:17] rate_zone,
	                                               // [23:19] zero
);

	rpk_pkg::cfg_t               cfg_q;
	rpk_pkg::cmd_t               push_cmd;
	rpk_pkg::cmd_t               pop_cmd;
	rpk_pkg::reg_idx_t           reg_idx;
	logic                        q_push;
	logic                        q_pop;
	logic                        q_full;
	logic                        q_empty;
	logic                        cfg_wr;
	logic                        beat_detected;
	logic [rpk_pkg::RATE_W-1:0]  heart_rate;
	logic [1:0]                  rate_zone;

	// Register file. The word index comes from the upper address bits.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = rpk_pkg::reg_idx_t'(paddr[rpk_pkg::PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.r_threshold        <= rpk_pkg::R_THRESHOLD_RST;
			cfg_q.refractory_samples <= rpk_pkg::REFRACTORY_RST;
			cfg_q.rate_numerator     <= rpk_pkg::NUMERATOR_RST;
			cfg_q.low_rate_limit     <= rpk_pkg::LOW_LIMIT_RST;
			cfg_q.high_rate_limit    <= rpk_pkg::HIGH_LIMIT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				rpk_pkg::REG_R_THRESHOLD: cfg_q.r_threshold        <= pwdata[15:0];
				rpk_pkg::REG_REFRACTORY:  cfg_q.refractory_samples <= pwdata[7:0];
				rpk_pkg::REG_NUMERATOR:   cfg_q.rate_numerator     <= pwdata[15:0];
				rpk_pkg::REG_LOW_LIMIT:   cfg_q.low_rate_limit     <= pwdata[15:0];
				rpk_pkg::REG_HIGH_LIMIT:  cfg_q.high_rate_limit    <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Reads sign-extend the threshold and zero-extend the others.
	always_comb begin
		case (reg_idx)
			rpk_pkg::REG_R_THRESHOLD: prdata = {{16{cfg_q.r_threshold[15]}}, cfg_q.r_threshold};
			rpk_pkg::REG_REFRACTORY:  prdata = {24'd0, cfg_q.refractory_samples};
			rpk_pkg::REG_NUMERATOR:   prdata = {16'd0, cfg_q.rate_numerator};
			rpk_pkg::REG_LOW_LIMIT:   prdata = {16'd0, cfg_q.low_rate_limit};
			rpk_pkg::REG_HIGH_LIMIT:  prdata = {16'd0, cfg_q.high_rate_limit};
			default:                  prdata = '0;
		endcase
	end

	// The front end classifies each sample as soon as it arrives.
	rpk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sample   (s_tdata),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	// Commands wait here while the divider is busy.
	rpk_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (push_cmd),
		.pop    (q_pop),
		.rd_cmd (pop_cmd),
		.full   (q_full),
		.empty  (q_empty)
	);

	// The back end computes the rate on beats and holds the result register.
	rpk_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_cmd         (pop_cmd),
		.q_pop         (q_pop),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.beat_detected (beat_detected),
		.heart_rate    (heart_rate),
		.rate_zone     (rate_zone)
	);

	assign m_tdata = {5'd0, rate_zone, heart_rate, beat_detected};

endmodule
